### hdl/lrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

	localparam int CHANNELS    = 256;
	localparam int QUEUE_DEPTH = 1023;

	localparam int ID_W   = 8;
	localparam int RTT_W  = 32;
	localparam int PKT_W  = 10;
	localparam int CHAN_W = $clog2(CHANNELS);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = ((CNT_W > PKT_W) ? CNT_W : PKT_W) + 1;

	typedef enum logic [1:0] {
		CMD_ENQ    = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_DEAD   = 2'd2,
		CMD_SCHED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CLS_CTRL = 2'd0,
		CLS_UND  = 2'd1,
		CLS_CLO  = 2'd2,
		CLS_OUT  = 2'd3
	} class_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_SENT     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NO_CHAN  = 3'd3,
		ST_SAT      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic             alive;
		logic             space;
		logic [RTT_W-1:0] rtt;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic upd;
		logic dead;
	} cell_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] value;
		logic             ovf;
	} sat_t;

	function automatic sat_t add_sat(input logic [CNT_W-1:0] c, input logic [PKT_W-1:0] n);
		logic [SUM_W-1:0] sum;
		sat_t             r;
		sum = SUM_W'(c) + SUM_W'(n);
		if (sum > SUM_W'(QUEUE_DEPTH)) begin
			r.value = CNT_W'(QUEUE_DEPTH);
			r.ovf   = 1'b1;
		end else begin
			r.value = sum[CNT_W-1:0];
			r.ovf   = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/lrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lrs_cell
	import lrs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [ID_W-1:0]  index,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [ID_W-1:0]  chan_id,
	input  wire logic [RTT_W-1:0] rtt,
	input  wire logic             has_space,
	input  wire entry_t           nxt,
	output entry_t                ent,
	output logic                  hit_alive
);

	logic             alive_q;
	logic             space_q;
	logic [RTT_W-1:0] rtt_q;
	logic             hit;

	assign hit       = (chan_id == index);
	assign hit_alive = hit && alive_q;

	assign ent.alive = alive_q;
	assign ent.space = space_q;
	assign ent.rtt   = rtt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
			space_q <= 1'b0;
		end else if (ctrl.shift) begin
			alive_q <= nxt.alive;
			space_q <= nxt.space;
		end else if (hit && ctrl.upd) begin
			alive_q <= 1'b1;
			space_q <= has_space;
		end else if (hit && ctrl.dead) begin
			alive_q <= 1'b0;
			space_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			rtt_q <= nxt.rtt;
		end else if (hit && ctrl.upd) begin
			rtt_q <= rtt;
		end
	end

endmodule

`default_nettype wire

### hdl/lowest_rtt_path_scheduler_unit.sv
// channel | signals                                           | direction
// in      | in_valid, in_stall, cmd, chan_id, rtt, has_space, | into block
//         | pkt_class, pkt_count                              |
// out     | out_valid, out_stall, status, sent_chan,          | out of block
//         | sent_class                                        |
//
// Enqueue, status update, dead report and a schedule request with nothing
// waiting load the output register; back to back unless out_stall holds.
// A schedule request with packets waiting rotates the channel table once
// through the row of cells, one entry per cycle past the comparator at the
// head; the input is stalled until the result is loaded.
// Reset clears alive and space marks of every cell at once; no clearing pass.
// The result sits in an output register; a new item is taken while it drains.
`timescale 1ns / 1ps
`default_nettype none

module lowest_rtt_path_scheduler_unit
	import lrs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       cmd,
	input  wire logic [ID_W-1:0]  chan_id,
	input  wire logic [RTT_W-1:0] rtt,
	input  wire logic             has_space,
	input  wire logic [1:0]       pkt_class,
	input  wire logic [PKT_W-1:0] pkt_count,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [2:0]            status,
	output logic [ID_W-1:0]       sent_chan,
	output logic [1:0]            sent_class
);

	state_t            state_q, state_nxt;
	logic              accept_in, out_free, pending, start_scan, last, finish, load_imm;
	logic              hit_any;
	cell_ctrl_t        cctrl;
	entry_t            ent [CHANNELS];
	logic [CHANNELS-1:0] hit_alive;

	logic              ctrl_q;
	logic [CNT_W-1:0]  und_q, clo_q, outg_q;
	logic [CNT_W-1:0]  target_cnt;
	sat_t              add;
	class_t            sel_cls;
	status_t           imm_status;

	logic [CHAN_W-1:0] idx_q;
	logic              found_q;
	logic [ID_W-1:0]   best_id_q;
	logic [RTT_W-1:0]  best_rtt_q;
	logic              take;

	logic              out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   chan_q;
	class_t            class_q;

	// row of cells, rotating towards cell 0 during a scan
	for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_cell
		lrs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (ID_W'(gi)),
			.ctrl      (cctrl),
			.chan_id   (chan_id),
			.rtt       (rtt),
			.has_space (has_space),
			.nxt       (ent[(gi + 1) % CHANNELS]),
			.ent       (ent[gi]),
			.hit_alive (hit_alive[gi])
		);
	end

	assign hit_any   = |hit_alive;
	assign out_free  = !out_valid_q || !out_stall;
	assign accept_in = in_valid && !in_stall;
	assign pending   = ctrl_q || (und_q != '0) || (clo_q != '0) || (outg_q != '0);
	assign start_scan = accept_in && (cmd == CMD_SCHED) && pending;
	assign load_imm  = accept_in && !start_scan;
	assign last      = (idx_q == CHAN_W'(CHANNELS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start_scan) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (last) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		finish      = 1'b0;
		unique case (state_q)
			S_IDLE: in_stall = !out_free;
			S_SCAN: in_stall = 1'b1;
			S_DONE: finish = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	assign cctrl.shift = (state_q == S_SCAN);
	assign cctrl.upd   = accept_in && (cmd == CMD_UPDATE);
	assign cctrl.dead  = accept_in && (cmd == CMD_DEAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// one saturating adder serves enqueue and dead reports
	always_comb begin
		if (cmd == CMD_DEAD) begin
			target_cnt = und_q;
		end else begin
			unique case (class_t'(pkt_class))
				CLS_UND:  target_cnt = und_q;
				CLS_CLO:  target_cnt = clo_q;
				CLS_OUT:  target_cnt = outg_q;
				default:  target_cnt = und_q;
			endcase
		end
	end

	assign add = add_sat(target_cnt, pkt_count);

	always_comb begin
		priority if (ctrl_q)         sel_cls = CLS_CTRL;
		else if (und_q != '0)        sel_cls = CLS_UND;
		else if (clo_q != '0)        sel_cls = CLS_CLO;
		else                         sel_cls = CLS_OUT;
	end

	always_comb begin
		unique case (cmd_t'(cmd))
			CMD_ENQ:    imm_status = ((class_t'(pkt_class) != CLS_CTRL) && add.ovf)
			                         ? ST_SAT : ST_ACCEPTED;
			CMD_UPDATE: imm_status = ST_ACCEPTED;
			CMD_DEAD:   imm_status = (hit_any && add.ovf) ? ST_SAT : ST_ACCEPTED;
			CMD_SCHED:  imm_status = ST_EMPTY;
			default:    imm_status = ST_ACCEPTED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= 1'b0;
			und_q  <= '0;
			clo_q  <= '0;
			outg_q <= '0;
		end else if (accept_in) begin
			unique case (cmd_t'(cmd))
				CMD_ENQ: begin
					unique case (class_t'(pkt_class))
						CLS_CTRL: ctrl_q <= 1'b1;
						CLS_UND:  und_q  <= add.value;
						CLS_CLO:  clo_q  <= add.value;
						CLS_OUT:  outg_q <= add.value;
						default:  ctrl_q <= ctrl_q;
					endcase
				end
				CMD_DEAD: begin
					if (hit_any) und_q <= add.value;
				end
				CMD_UPDATE, CMD_SCHED: begin
					ctrl_q <= ctrl_q;
				end
				default: ctrl_q <= ctrl_q;
			endcase
		end else if (finish && found_q) begin
			unique case (sel_cls)
				CLS_CTRL: ctrl_q <= 1'b0;
				CLS_UND:  und_q  <= und_q - 1'b1;
				CLS_CLO:  clo_q  <= clo_q - 1'b1;
				CLS_OUT:  outg_q <= outg_q - 1'b1;
				default:  ctrl_q <= ctrl_q;
			endcase
		end
	end

	// head of the row is channel idx_q; strict < keeps the lowest id on ties
	assign take = ent[0].alive && ent[0].space && (!found_q || (ent[0].rtt < best_rtt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (start_scan) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cctrl.shift) begin
			idx_q <= idx_q + 1'b1;
			if (take) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cctrl.shift && take) begin
			best_id_q  <= ID_W'(idx_q);
			best_rtt_q <= ent[0].rtt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_imm || finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_imm) begin
			status_q <= imm_status;
			chan_q   <= '0;
			class_q  <= CLS_CTRL;
		end else if (finish) begin
			status_q <= found_q ? ST_SENT : ST_NO_CHAN;
			chan_q   <= found_q ? best_id_q : '0;
			class_q  <= found_q ? sel_cls : CLS_CTRL;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign sent_chan  = chan_q;
	assign sent_class = class_q;

	a_no_transfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !accept_in)
		else $error("input transfer taken while a scan is in progress");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_scan |=> (state_q == S_SCAN) && (idx_q == '0) && !found_q)
		else $error("scan did not start from the head with no pick");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !last) |=>
			(state_q == S_SCAN) && (idx_q == $past(idx_q) + 1'b1))
		else $error("scan index did not advance by one");

	a_sent_result: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && found_q) |=> out_valid_q && (status_q == ST_SENT))
		else $error("finished scan with a pick did not report a send");

endmodule

`default_nettype wire
